// ----- rtl/lxcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Line XOR checksum checker package
// Shared constants, control types and character helper functions.
// ----------------------------------------------------------------------------
package lxcc_pkg;

    // Default longest line, in bytes, before the overflow flag is set.
    localparam int unsigned LINE_MAX_DEF = 1024;

    // Width of the reported line length.
    localparam int unsigned LEN_W = 11;

    // Characters of interest.
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Input item kinds carried in tuser.
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } t_op;

    // Commands from the input stage to the line tracker.
    typedef struct packed {
        logic byte_en;
        logic line_end;
    } t_trk_ctrl;

    // Snapshot of the line as it stood at its last non-whitespace byte.
    typedef struct packed {
        logic [7:0] tail_third;
        logic [7:0] tail_second;
        logic [7:0] tail_last;
        logic [7:0] xor_before_tail;
        logic       overflow;
    } t_snap;

    // Decoded hex digit: a valid flag and the digit value.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    // True for space, tab, CR and LF.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Decodes one hex digit in either case.
    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex       h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            h.valid = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            d = c - CH_LA + 8'd10;
            h.valid = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
            h.valid = 1'b1;
        end
        h.value = d[3:0];
        return h;
    endfunction

endpackage

// ----- rtl/line_xor_checksum_checker.sv -----
// ----------------------------------------------------------------------------
// Line XOR checksum checker
// Checks received text lines against an optional "@hh" XOR suffix.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one item per cycle when s_tready is high: tuser
// low: a line byte in tdata; tuser high: end of the line (tdata is ignored).
// Each end-of-line item gives one result item on the master channel with
// the stripped length, the checksum flag and the overflow flag.
// Line bytes give no result.
// An item is registered in the input stage, and an end-of-line item then
// loads the result register that drives the master channel. Throughput
// is one item per cycle unless an end item waits for a held result, set
// by the single update of the tracker registers per cycle.
// Reset clears the input stage, the line state and the result register.
// When the receiver stalls, the result stays held; line bytes keep flowing
// until the next end-of-line item waits in the input stage, and then
// s_tready drops until the held result is taken.
// ----------------------------------------------------------------------------
module line_xor_checksum_checker import lxcc_pkg::*; #(
    parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [10:0] line_length, [11] sum_match,
                                   // [12] too_long, [15:13] zero
);

    localparam int unsigned CW = $clog2(LINE_MAX + 1);

    logic             r_in_valid;
    t_op              r_in_op;
    logic [7:0]       r_in_byte;
    logic             w_out_free;
    logic             w_adv;
    t_trk_ctrl        w_ctrl;
    logic [CW-1:0]    w_kept_length;
    t_snap            w_snap;
    logic [LEN_W-1:0] w_line_length;
    logic             w_sum_match;
    logic             w_too_long;

    // The input stage moves on unless an end item waits for the result slot.
    assign w_adv    = r_in_valid && ((r_in_op == OP_BYTE) || w_out_free);
    assign s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_op   <= t_op'(s_tuser);
            r_in_byte <= s_tdata;
        end
    end

    // Tracker commands.
    assign w_ctrl.byte_en  = w_adv && (r_in_op == OP_BYTE);
    assign w_ctrl.line_end = w_adv && (r_in_op == OP_END);

    lxcc_track #(
        .LINE_MAX (LINE_MAX),
        .CW       (CW)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_byte        (r_in_byte),
        .o_kept_length (w_kept_length),
        .o_snap        (w_snap)
    );

    lxcc_verify #(
        .CW (CW)
    ) u_verify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_ctrl.line_end),
        .i_kept_length (w_kept_length),
        .i_snap        (w_snap),
        .i_ready       (m_tready),
        .o_free        (w_out_free),
        .o_valid       (m_tvalid),
        .o_line_length (w_line_length),
        .o_sum_match   (w_sum_match),
        .o_too_long    (w_too_long)
    );

    assign m_tdata = {3'b000, w_too_long, w_sum_match, w_line_length};

`ifndef NO_ASSERTIONS
    // An end item that moves on always produces a result next cycle.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.line_end) |=> m_tvalid)
        else $error("end item produced no result");

    // An end item only waits while a result is held and stalled.
    a_end_wait_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_op == OP_END) && !w_adv) |-> (m_tvalid && !m_tready))
        else $error("end item stalled without a blocked result");

    // A line byte never creates a result.
    a_byte_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.byte_en && !m_tvalid) |=> !m_tvalid)
        else $error("line byte produced a result");

    // The line state is cleared after each end of line.
    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.line_end) |=> ((w_kept_length == '0) && !w_snap.overflow))
        else $error("line state not cleared after end of line");
`endif

endmodule

// ----- rtl/lxcc_track.sv -----
// ----------------------------------------------------------------------------
// Line tracker
// Keeps the byte count, running XOR, the last three bytes with their prefix
// XORs, and the snapshot taken at each non-whitespace byte.
// ----------------------------------------------------------------------------
module lxcc_track import lxcc_pkg::*; #(
    parameter int unsigned LINE_MAX = LINE_MAX_DEF,
    parameter int unsigned CW       = $clog2(LINE_MAX + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_trk_ctrl     i_ctrl,
    input  logic [7:0]    i_byte,
    output logic [CW-1:0] o_kept_length,
    output t_snap         o_snap
);

    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_rb [3];
    logic [7:0]    n_rb [3];
    logic [7:0]    r_px [3];
    logic [7:0]    n_px [3];
    logic [CW-1:0] r_kept_len, n_kept_len;
    t_snap         r_snap, n_snap;

    // Next state for one line byte or the end of a line.
    always_comb begin
        n_count    = r_count;
        n_xor      = r_xor;
        n_rb       = r_rb;
        n_px       = r_px;
        n_kept_len = r_kept_len;
        n_snap     = r_snap;
        if (i_ctrl.line_end) begin
            n_count    = '0;
            n_xor      = '0;
            n_rb       = '{default: '0};
            n_px       = '{default: '0};
            n_kept_len = '0;
            n_snap     = '0;
        end else if (i_ctrl.byte_en) begin
            if (r_count >= CW'(LINE_MAX)) begin
                // Bytes past the limit are dropped.
                n_snap.overflow = 1'b1;
            end else begin
                n_rb[0] = r_rb[1];
                n_rb[1] = r_rb[2];
                n_rb[2] = i_byte;
                n_px[0] = r_px[1];
                n_px[1] = r_px[2];
                n_px[2] = r_xor;
                n_xor   = r_xor ^ i_byte;
                n_count = r_count + CW'(1);
                if (!is_space(i_byte)) begin
                    n_kept_len             = r_count + CW'(1);
                    n_snap.tail_third      = r_rb[1];
                    n_snap.tail_second     = r_rb[2];
                    n_snap.tail_last       = i_byte;
                    n_snap.xor_before_tail = r_px[1];
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_xor      <= '0;
            r_rb       <= '{default: '0};
            r_px       <= '{default: '0};
            r_kept_len <= '0;
            r_snap     <= '0;
        end else begin
            r_count    <= n_count;
            r_xor      <= n_xor;
            r_rb       <= n_rb;
            r_px       <= n_px;
            r_kept_len <= n_kept_len;
            r_snap     <= n_snap;
        end
    end

    assign o_kept_length = r_kept_len;
    assign o_snap        = r_snap;

endmodule

// ----- rtl/lxcc_verify.sv -----
// ----------------------------------------------------------------------------
// Suffix verifier
// Checks the "@hh" suffix of the stripped line and holds the result item
// until the receiver takes it.
// ----------------------------------------------------------------------------
module lxcc_verify import lxcc_pkg::*; #(
    parameter int unsigned CW = $clog2(LINE_MAX_DEF + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [CW-1:0]    i_kept_length,
    input  t_snap            i_snap,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output logic [LEN_W-1:0] o_line_length,
    output logic             o_sum_match,
    output logic             o_too_long
);

    t_hex             w_hi;
    t_hex             w_lo;
    logic             w_has_suffix;
    logic             w_match;
    logic [CW-1:0]    w_len;
    logic             r_valid, n_valid;
    logic [LEN_W-1:0] r_len;
    logic             r_ok;
    logic             r_long;

    // Suffix decode and compare against the XOR before the '@'.
    always_comb begin
        w_hi         = hex_digit(i_snap.tail_second);
        w_lo         = hex_digit(i_snap.tail_last);
        w_has_suffix = (i_kept_length >= CW'(3)) && (i_snap.tail_third == CH_AT);
        w_match      = w_hi.valid && w_lo.valid &&
                       ({w_hi.value, w_lo.value} == i_snap.xor_before_tail);
        w_len        = (w_has_suffix && w_match) ? i_kept_length - CW'(3)
                                                 : i_kept_length;
    end

    // The result register is free when empty or being taken.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_len  <= LEN_W'(w_len);
            r_ok   <= !w_has_suffix || w_match;
            r_long <= i_snap.overflow;
        end
    end

    assign o_valid       = r_valid;
    assign o_line_length = r_len;
    assign o_sum_match   = r_ok;
    assign o_too_long    = r_long;

endmodule
